// ===== rtl/rpcd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpcd_pkg
// Shared types and codes of the rigid point-to-curve distance block.
// ----------------------------------------------------------------------------
package rpcd_pkg;

    // action codes of an input beat
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_COS      = 2'd0;
    localparam logic [1:0] CFG_SIN      = 2'd1;
    localparam logic [1:0] CFG_OFFSET_X = 2'd2;
    localparam logic [1:0] CFG_OFFSET_Y = 2'd3;

    localparam logic [15:0] COS_RESET = 16'sd16384;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } in_item_t;

    typedef struct packed {
        logic [31:0] distance;
        logic        no_curve;
    } out_item_t;

    // work handed from the front end to the back end
    typedef enum logic {
        OP_LOAD,
        OP_QUERY
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_SCAN,
        ST_ROOT,
        ST_HOLD
    } back_state_t;

endpackage : rpcd_pkg
`default_nettype wire

// ===== rtl/rpcd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpcd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rpcd_fifo
    import rpcd_pkg::*;
#(
    parameter int WIDTH = 66
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      fill_reg;
    logic [PW:0]      fill_next;

    assign full      = (fill_reg == (PW+1)'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule : rpcd_fifo
`default_nettype wire

// ===== rtl/rpcd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpcd_front
// Input side: takes beats, tracks the vertex count, drops loads into a full
// store and unused actions, and queues loads and queries for the back end.
// ----------------------------------------------------------------------------
module rpcd_front
    import rpcd_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire in_item_t                              in_item,
    input  wire logic                                  q_full,
    output logic                                       q_push,
    output cmd_t                                       q_cmd,
    output logic [$clog2(MAX_VERTICES + 1)-1:0]        q_count
);

    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic          accept;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // loads carry their store address, queries the number of stored vertices
    assign q_count  = count_reg;

    always_comb
    begin
        count_next = count_reg;
        q_push     = 1'b0;
        q_cmd.op   = OP_LOAD;
        q_cmd.x    = in_item.point_x;
        q_cmd.y    = in_item.point_y;
        if (accept)
        begin
            unique case (in_item.action)
                ACT_LOAD:
                begin
                    if (count_reg < CW'(MAX_VERTICES))
                    begin
                        q_push     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_QUERY:
                begin
                    q_push   = 1'b1;
                    q_cmd.op = OP_QUERY;
                end
                ACT_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule : rpcd_front
`default_nettype wire

// ===== rtl/rpcd_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpcd_isqrt
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module rpcd_isqrt
    import rpcd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] value,
    output logic             done,
    output logic [31:0]      root
);

    logic [63:0] rad_reg;
    logic [34:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [34:0] rem_shift;
    logic [34:0] trial;
    logic        fits;

    assign rem_shift = {rem_reg[32:0], rad_reg[63:62]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);
    assign done      = done_reg;
    assign root      = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[61:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

endmodule : rpcd_isqrt
`default_nettype wire

// ===== rtl/rpcd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpcd_back
// Execution side: vertex store, query transform, nearest-vertex scan and
// square root, with the result register.
// ----------------------------------------------------------------------------
module rpcd_back
    import rpcd_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   q_valid,
    input  wire cmd_t                                   q_cmd,
    input  wire logic [$clog2(MAX_VERTICES + 1)-1:0]    q_count,
    output logic                                        q_pop,
    input  wire logic signed [15:0]                     cos_angle,
    input  wire logic signed [15:0]                     sin_angle,
    input  wire logic signed [31:0]                     offset_x,
    input  wire logic signed [31:0]                     offset_y,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output out_item_t                                   out_item
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    back_state_t state_reg;
    back_state_t state_next;

    // vertex store, x in the high half
    logic [63:0] mem [MAX_VERTICES];
    logic [63:0] rdata_reg;
    logic        mem_we;

    logic signed [31:0] qx_reg;
    logic signed [31:0] qy_reg;
    logic [CW-1:0]      count_reg;
    logic signed [47:0] p_xc_reg;
    logic signed [47:0] p_ys_reg;
    logic signed [47:0] p_yc_reg;
    logic signed [47:0] p_xs_reg;
    logic [34:0]        x2_reg;
    logic [34:0]        y2_reg;
    logic [34:0]        x2_next;
    logic [34:0]        y2_next;

    // scan pipeline: read, magnitude, square, minimum
    logic [CW-1:0] issue_reg;
    logic          scan_issue;
    logic          scan_done;
    logic          v1_reg;
    logic          v2_reg;
    logic          v3_reg;
    logic [35:0]   dx;
    logic [35:0]   dy;
    logic [35:0]   ax;
    logic [35:0]   ay;
    logic [31:0]   ax_reg;
    logic [31:0]   ay_reg;
    logic          satx_reg;
    logic          saty_reg;
    logic [63:0]   sqx_reg;
    logic [63:0]   sqy_reg;
    logic          sat3_reg;
    logic [64:0]   d2_sum;
    logic [63:0]   d2;
    logic [63:0]   best_reg;

    logic        sqrt_done;
    logic [31:0] sqrt_root;

    logic [31:0] res_dist_reg;
    logic        res_flag_reg;
    logic        out_load;
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    assign out_valid = out_valid_reg;
    assign out_item  = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_cmd.op == OP_QUERY)
                begin
                    state_next = (q_count == '0) ? ST_HOLD : ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop      = (state_reg == ST_IDLE) && q_valid;
        mem_we     = q_pop && (q_cmd.op == OP_LOAD);
        scan_issue = (state_reg == ST_SCAN) && (issue_reg != count_reg);
        scan_done  = (state_reg == ST_SCAN) && (issue_reg == count_reg)
                     && !v1_reg && !v2_reg && !v3_reg;
        out_load   = (state_reg == ST_HOLD) && (!out_valid_reg || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SUM)
            begin
                issue_reg <= '0;
            end
            else if (scan_issue)
            begin
                issue_reg <= issue_reg + 1'b1;
            end
            v1_reg <= scan_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[q_count[AW-1:0]] <= {q_cmd.x, q_cmd.y};
        end
        if (scan_issue)
        begin
            rdata_reg <= mem[issue_reg[AW-1:0]];
        end
    end

    // floor of each Q2.14 product is its arithmetic shift
    assign x2_next = {p_xc_reg[47], p_xc_reg[47:14]} + {p_ys_reg[47], p_ys_reg[47:14]}
                     + {{3{offset_x[31]}}, offset_x};
    assign y2_next = {p_yc_reg[47], p_yc_reg[47:14]} - {p_xs_reg[47], p_xs_reg[47:14]}
                     + {{3{offset_y[31]}}, offset_y};

    assign dx = {x2_reg[34], x2_reg} - {{4{rdata_reg[63]}}, rdata_reg[63:32]};
    assign dy = {y2_reg[34], y2_reg} - {{4{rdata_reg[31]}}, rdata_reg[31:0]};
    assign ax = dx[35] ? (36'd0 - dx) : dx;
    assign ay = dy[35] ? (36'd0 - dy) : dy;

    // saturating sum of the two squares
    assign d2_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign d2     = (sat3_reg || d2_sum[64]) ? '1 : d2_sum[63:0];

    always_ff @(posedge clk)
    begin
        if (q_pop && q_cmd.op == OP_QUERY)
        begin
            qx_reg       <= q_cmd.x;
            qy_reg       <= q_cmd.y;
            count_reg    <= q_count;
            res_flag_reg <= (q_count == '0);
            res_dist_reg <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            p_xc_reg <= qx_reg * cos_angle;
            p_ys_reg <= qy_reg * sin_angle;
            p_yc_reg <= qy_reg * cos_angle;
            p_xs_reg <= qx_reg * sin_angle;
        end
        if (state_reg == ST_SUM)
        begin
            x2_reg   <= x2_next;
            y2_reg   <= y2_next;
            best_reg <= '1;
        end
        if (v1_reg)
        begin
            ax_reg   <= ax[31:0];
            ay_reg   <= ay[31:0];
            satx_reg <= |ax[35:32];
            saty_reg <= |ay[35:32];
        end
        if (v2_reg)
        begin
            sqx_reg  <= ax_reg * ax_reg;
            sqy_reg  <= ay_reg * ay_reg;
            sat3_reg <= satx_reg || saty_reg;
        end
        if (v3_reg && (d2 < best_reg))
        begin
            best_reg <= d2;
        end
        if (state_reg == ST_ROOT && sqrt_done)
        begin
            res_dist_reg <= sqrt_root;
        end
        if (out_load)
        begin
            out_data_reg.distance <= res_dist_reg;
            out_data_reg.no_curve <= res_flag_reg;
        end
    end

    rpcd_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_done),
        .value (best_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

endmodule : rpcd_back
`default_nettype wire

// ===== rtl/rigid_point_to_curve_distance.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rigid_point_to_curve_distance
// Distance from a rotated and translated query point to the nearest stored
// curve vertex, in Q16.16.
// ----------------------------------------------------------------------------
// A front end takes input beats, keeps the vertex count, drops loads into a
// full store and unused actions, and applies clears at once; loads and
// queries go through a four-deep queue to the back end, so the input keeps
// flowing while a query is scanned until the queue is full. The back end
// writes a load to the vertex store from its idle state. A query against an
// empty store goes from the idle state straight to the hold state and gives
// distance 0 with no_curve set. Any other query is taken from the queue,
// its point is transformed (products, then sums), the stored vertices are
// scanned (one vertex per cycle through the single read port of the vertex
// store, through three pipeline stages, until the pipeline drains), the
// bit-serial square root runs, and the result register is loaded. The result
// sits in an output register, so the next queued work starts while a result
// beat is still stalled; only a second finished query waits for it.
// Configuration writes are taken at any time but belong to idle periods.
module rigid_point_to_curve_distance
    import rpcd_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_item,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_item
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int QW = $bits(cmd_t) + CW;

    // configuration registers
    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_reg;
    logic signed [31:0] offset_x_reg;
    logic signed [31:0] offset_y_reg;

    // front end to queue
    logic          push;
    cmd_t          push_cmd;
    logic [CW-1:0] push_count;
    logic          q_full;

    // queue to back end
    logic          pop;
    logic          q_valid;
    logic [QW-1:0] q_data;
    cmd_t          pop_cmd;
    logic [CW-1:0] pop_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg      <= COS_RESET;
            sin_reg      <= '0;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COS:      cos_reg      <= cfg_data[15:0];
                CFG_SIN:      sin_reg      <= cfg_data[15:0];
                CFG_OFFSET_X: offset_x_reg <= cfg_data;
                CFG_OFFSET_Y: offset_y_reg <= cfg_data;
                default:      cos_reg      <= cos_reg;
            endcase
        end
    end

    rpcd_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_full   (q_full),
        .q_push   (push),
        .q_cmd    (push_cmd),
        .q_count  (push_count)
    );

    rpcd_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_cmd, push_count}),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    // command in the high bits, count or store address below
    assign pop_cmd   = cmd_t'(q_data[QW-1:CW]);
    assign pop_count = q_data[CW-1:0];

    rpcd_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (pop_cmd),
        .q_count   (pop_count),
        .q_pop     (pop),
        .cos_angle (cos_reg),
        .sin_angle (sin_reg),
        .offset_x  (offset_x_reg),
        .offset_y  (offset_y_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule : rigid_point_to_curve_distance
`default_nettype wire
